// ===== hw/rtl/capture_period_speed_meter_assert.svh =====
// Assertion macros shared by the speed meter RTL.
`ifndef CAPTURE_PERIOD_SPEED_METER_ASSERT_SVH
`define CAPTURE_PERIOD_SPEED_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPSM_ASSERT_NOW(lbl, ante, cons, msg)
`define CPSM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cpsm_pkg.sv =====
package cpsm_pkg;

  localparam int NUM_W     = 40;
  localparam int NUM100_W  = NUM_W + 7;
  localparam int CAP_W     = 16;
  localparam int OVF_W     = 16;
  localparam int STAMP_W   = OVF_W + CAP_W;
  localparam int EDGE_W    = 8;
  localparam int PRE_W     = 3;
  localparam int SPEED_W   = 32;
  localparam int LEVEL_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SHIFT_W   = 4;
  localparam int DVD_W     = 40;
  localparam int DVS_W     = STAMP_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Level scaling: floor(x * 17 / 20) as ((x * 17) >> 2) times a reciprocal of 5.
  localparam int LVL_W      = 17;
  localparam int LVL17_W    = LVL_W + 4;
  localparam int LVL_Y_W    = LVL17_W - 2;
  localparam int RECIP_SH   = 21;
  localparam int PROD_W     = 2 * LVL_Y_W;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PRE_W-1:0]     pre_code_t;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_ZERO = 2'd1;
  localparam status_t STATUS_STOP = 2'd2;

  localparam cfg_idx_t CFG_PRESCALE  = 2'd0;
  localparam cfg_idx_t CFG_NUMERATOR = 2'd1;
  localparam cfg_idx_t CFG_EDGES     = 2'd2;

  localparam pre_code_t PRE_DIV1    = 3'd1;
  localparam pre_code_t PRE_DIV8    = 3'd2;
  localparam pre_code_t PRE_DIV64   = 3'd3;
  localparam pre_code_t PRE_DIV256  = 3'd4;
  localparam pre_code_t PRE_DIV1024 = 3'd5;

  localparam pre_code_t          PRESCALE_RESET  = PRE_DIV1;
  localparam logic [NUM_W-1:0]   NUMERATOR_RESET = 40'd900756685;
  localparam logic [EDGE_W-1:0]  EDGES_RESET     = 8'd4;

  localparam logic [DVD_W-1:0]   LEVEL_SAT_LIMIT = 40'd77102;
  localparam logic [LVL_Y_W-1:0] RECIP5          = 19'd419431;

  typedef struct packed {
    logic start_q;
    logic start_l;
    logic take_q;
    logic take_l;
    logic mul;
    logic fin_ok;
    logic fin_err;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic bad;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/capture_period_speed_meter.sv =====
// Input-capture tachometer. Overflow ticks and capture edges that do not close
// a sample are taken without stalling the input. The edge that closes a sample
// of edges_per_sample edges stalls the input while one 40-step radix-2 divider
// runs twice, once for speed_q8 and once for the speed level, followed by a
// constant multiply for the level scaling. A zero period or a stopped prescaler
// skips the divider. The result sits in an output register, so the next word is
// accepted while it waits; if the next result is ready before the receiver has
// taken the previous one, the input stays stalled until the output register is
// free.
module capture_period_speed_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpsm_pkg::NUM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [cpsm_pkg::CAP_W-1:0]     in_capture_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cpsm_pkg::SPEED_W-1:0]   out_speed_q8,
  output logic [cpsm_pkg::LEVEL_W-1:0]   out_speed_level,
  output logic [cpsm_pkg::STATUS_W-1:0]  out_status
);

  cpsm_pkg::cmd_t cmd;
  cpsm_pkg::sts_t sts;
  logic           in_accept;
  logic           cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_accept = in_valid && !in_stall;

  cpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  cpsm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_accept        (in_accept),
    .in_action        (in_action),
    .in_capture_value (in_capture_value),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_speed_q8     (out_speed_q8),
    .out_speed_level  (out_speed_level),
    .out_status       (out_status)
  );

endmodule

// ===== hw/rtl/cpsm_div.sv =====
`include "capture_period_speed_meter_assert.svh"

module cpsm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cpsm_pkg::DVD_W-1:0]  dividend,
  input  logic [cpsm_pkg::DVS_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [cpsm_pkg::DVD_W-1:0]  quotient
);

  logic [cpsm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [cpsm_pkg::DVS_W-1:0]     rem_r;
  logic [cpsm_pkg::DVS_W-1:0]     rem_nxt;
  logic [cpsm_pkg::DVS_W-1:0]     dvs_r;
  logic [cpsm_pkg::DVD_W-1:0]     quo_r;
  logic [cpsm_pkg::DVD_W-1:0]     quo_nxt;
  logic [cpsm_pkg::DVS_W:0]       shl;
  logic [cpsm_pkg::DVS_W:0]       diff;
  logic                           ge;

  always_comb begin
    shl     = {rem_r, quo_r[cpsm_pkg::DVD_W-1]};
    diff    = shl - {1'b0, dvs_r};
    ge      = (shl >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[cpsm_pkg::DVS_W-1:0] : shl[cpsm_pkg::DVS_W-1:0];
    quo_nxt = {quo_r[cpsm_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= cpsm_pkg::DIV_CNT_W'(cpsm_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cpsm_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

  `CPSM_ASSERT_NOW(a_rem_below_divisor, done_r, rem_r < dvs_r, "divider remainder not below divisor")

endmodule

// ===== hw/rtl/cpsm_dp.sv =====
`include "capture_period_speed_meter_assert.svh"

module cpsm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpsm_pkg::NUM_W-1:0]     cfg_data,
  input  logic                           in_accept,
  input  logic                           in_action,
  input  logic [cpsm_pkg::CAP_W-1:0]     in_capture_value,
  input  logic                           out_stall,
  input  cpsm_pkg::cmd_t                 cmd,
  output cpsm_pkg::sts_t                 sts,
  output logic                           out_valid,
  output logic [cpsm_pkg::SPEED_W-1:0]   out_speed_q8,
  output logic [cpsm_pkg::LEVEL_W-1:0]   out_speed_level,
  output logic [cpsm_pkg::STATUS_W-1:0]  out_status
);

  logic [cpsm_pkg::PRE_W-1:0]    prescale_r;
  logic [cpsm_pkg::NUM_W-1:0]    num_r;
  logic [cpsm_pkg::EDGE_W-1:0]   eps_r;

  logic [cpsm_pkg::OVF_W-1:0]    ovf_r;
  logic [cpsm_pkg::STAMP_W-1:0]  last_stamp_r;
  logic [cpsm_pkg::EDGE_W-1:0]   edge_r;
  logic [cpsm_pkg::EDGE_W-1:0]   edge_nxt;

  logic [cpsm_pkg::STAMP_W-1:0]  stamp;
  logic [cpsm_pkg::STAMP_W-1:0]  period_r;
  logic [cpsm_pkg::SHIFT_W-1:0]  shift_r;
  logic [cpsm_pkg::SHIFT_W-1:0]  shift_nxt;
  logic                          stopped_r;
  logic                          stopped_nxt;
  logic                          hit;

  logic [cpsm_pkg::NUM100_W-1:0]   num100;
  logic [cpsm_pkg::NUM100_W-9:0]   num100_hi;
  logic [cpsm_pkg::DVD_W-1:0]      dvd_q;
  logic [cpsm_pkg::DVD_W-1:0]      dvd_l;
  logic [cpsm_pkg::DVD_W-1:0]      dvd;
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [cpsm_pkg::DVD_W-1:0]      quo;

  logic [cpsm_pkg::SPEED_W-1:0]    speed_r;
  logic                            lsat_r;
  logic [cpsm_pkg::LVL17_W-1:0]    x17;
  logic [cpsm_pkg::LVL_Y_W-1:0]    y_r;
  logic [cpsm_pkg::PROD_W-1:0]     prod_r;
  logic [cpsm_pkg::LEVEL_W-1:0]    level;

  logic                            out_valid_r;
  logic [cpsm_pkg::SPEED_W-1:0]    out_speed_r;
  logic [cpsm_pkg::LEVEL_W-1:0]    out_level_r;
  logic [cpsm_pkg::STATUS_W-1:0]   out_status_r;
  logic                            out_free;

  always_comb begin
    stamp    = {ovf_r, in_capture_value};
    edge_nxt = edge_r + 1'b1;
    hit      = in_action && (edge_nxt == eps_r);
    case (prescale_r)
      cpsm_pkg::PRE_DIV1: begin
        shift_nxt   = 4'd0;
        stopped_nxt = 1'b0;
      end
      cpsm_pkg::PRE_DIV8: begin
        shift_nxt   = 4'd3;
        stopped_nxt = 1'b0;
      end
      cpsm_pkg::PRE_DIV64: begin
        shift_nxt   = 4'd6;
        stopped_nxt = 1'b0;
      end
      cpsm_pkg::PRE_DIV256: begin
        shift_nxt   = 4'd8;
        stopped_nxt = 1'b0;
      end
      cpsm_pkg::PRE_DIV1024: begin
        shift_nxt   = 4'd10;
        stopped_nxt = 1'b0;
      end
      default: begin
        shift_nxt   = 4'd0;
        stopped_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= cpsm_pkg::PRESCALE_RESET;
      num_r      <= cpsm_pkg::NUMERATOR_RESET;
      eps_r      <= cpsm_pkg::EDGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cpsm_pkg::CFG_PRESCALE:  prescale_r <= cfg_data[cpsm_pkg::PRE_W-1:0];
        cpsm_pkg::CFG_NUMERATOR: num_r      <= cfg_data;
        cpsm_pkg::CFG_EDGES:     eps_r      <= cfg_data[cpsm_pkg::EDGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r        <= '0;
      last_stamp_r <= '0;
      edge_r       <= '0;
    end else if (in_accept) begin
      if (!in_action) begin
        ovf_r <= ovf_r + 1'b1;
      end else if (hit) begin
        last_stamp_r <= stamp;
        edge_r       <= '0;
      end else begin
        edge_r <= edge_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && hit) begin
      period_r  <= stamp - last_stamp_r;
      shift_r   <= shift_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // The prescaler divide is a power of two, so it folds into the dividend.
  always_comb begin
    num100    = {1'b0, num_r, 6'b0} + {2'b0, num_r, 5'b0} + {5'b0, num_r, 2'b0};
    num100_hi = num100[cpsm_pkg::NUM100_W-1:8];
    dvd_q     = num_r >> shift_r;
    dvd_l     = cpsm_pkg::DVD_W'(num100_hi >> shift_r);
    dvd       = cmd.start_l ? dvd_l : dvd_q;
    div_start = cmd.start_q || cmd.start_l;
  end

  cpsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (period_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    x17   = {quo[cpsm_pkg::LVL_W-1:0], 4'b0} +
            cpsm_pkg::LVL17_W'(quo[cpsm_pkg::LVL_W-1:0]);
    level = lsat_r ? '1 : prod_r[cpsm_pkg::RECIP_SH+cpsm_pkg::LEVEL_W-1:cpsm_pkg::RECIP_SH];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_q) begin
      speed_r <= (quo[cpsm_pkg::DVD_W-1:cpsm_pkg::SPEED_W] != '0) ? '1 :
                 quo[cpsm_pkg::SPEED_W-1:0];
    end
    if (cmd.take_l) begin
      lsat_r <= (quo >= cpsm_pkg::LEVEL_SAT_LIMIT);
      y_r    <= x17[cpsm_pkg::LVL17_W-1:2];
    end
    if (cmd.mul) begin
      prod_r <= cpsm_pkg::PROD_W'(y_r) * cpsm_pkg::PROD_W'(cpsm_pkg::RECIP5);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_ok || cmd.fin_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_ok) begin
      out_speed_r  <= speed_r;
      out_level_r  <= level;
      out_status_r <= cpsm_pkg::STATUS_OK;
    end else if (cmd.fin_err) begin
      out_speed_r  <= '1;
      out_level_r  <= '1;
      out_status_r <= stopped_r ? cpsm_pkg::STATUS_STOP : cpsm_pkg::STATUS_ZERO;
    end
  end

  always_comb begin
    sts.hit      = hit;
    sts.bad      = stopped_r || (period_r == '0);
    sts.div_done = div_done;
    sts.out_free = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_speed_q8    = out_speed_r;
  assign out_speed_level = out_level_r;
  assign out_status      = out_status_r;

  `CPSM_ASSERT_NEXT(a_edge_clear, in_accept && hit, edge_r == '0, "edge count not cleared")
  `CPSM_ASSERT_NOW(a_div_idle_start, div_start, !div_busy, "divider restarted while busy")

endmodule

// ===== hw/rtl/cpsm_ctrl.sv =====
`include "capture_period_speed_meter_assert.svh"

module cpsm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  cpsm_pkg::sts_t  sts,
  output cpsm_pkg::cmd_t  cmd,
  output logic            in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIVQ,
    S_DIVL,
    S_MUL,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   err_r;
  logic   err_nxt;
  logic   stall_r;

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && sts.hit) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.bad) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          err_nxt     = 1'b0;
          cmd.start_q = 1'b1;
          state_nxt   = S_DIVQ;
        end
      end
      S_DIVQ: begin
        if (sts.div_done) begin
          cmd.take_q  = 1'b1;
          cmd.start_l = 1'b1;
          state_nxt   = S_DIVL;
        end
      end
      S_DIVL: begin
        if (sts.div_done) begin
          cmd.take_l = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin_ok  = !err_r;
          cmd.fin_err = err_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = stall_r;

  `CPSM_ASSERT_NOW(a_fin_slot_free, cmd.fin_ok || cmd.fin_err, sts.out_free, "result written into a full output register")

endmodule

// ===== tb/capture_period_speed_meter_tb.sv =====
`timescale 1ns / 100ps

module capture_period_speed_meter_tb;
  import cpsm_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD = 600;

  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  localparam pre_code_t PRE_STOPPED = 3'd0;
  localparam pre_code_t PRE_UNUSED6 = 3'd6;
  localparam pre_code_t PRE_UNUSED7 = 3'd7;

  localparam logic [NUM_W-1:0] NUMERATOR_MAX = '1;
  localparam logic [63:0] SPEED_MAX = 64'hFFFF_FFFF;
  localparam logic [63:0] LEVEL_MAX = 64'd65535;
  localparam logic [63:0] LEVEL_PERCENT = 64'd100;
  localparam logic [63:0] LEVEL_OUT_SPAN = 64'd765;
  localparam logic [63:0] LEVEL_IN_SPAN = 64'd900;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic             is_capture;
    logic [CAP_W-1:0] capture;
  } meter_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [LEVEL_W-1:0] level;
    status_t            status;
  } speed_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index = '0;
  logic [NUM_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = 1'b0;
  logic [CAP_W-1:0]    in_capture_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SPEED_W-1:0]  out_speed_q8;
  logic [LEVEL_W-1:0]  out_speed_level;
  logic [STATUS_W-1:0] out_status;

  meter_word_t   pending_words[$];
  speed_result_t expected_speeds[$];
  int            failures = 0;
  int            words_queued = 0;

  pre_code_t          prescale_cfg = PRESCALE_RESET;
  logic [NUM_W-1:0]   numerator_cfg = NUMERATOR_RESET;
  logic [EDGE_W-1:0]  edges_cfg = EDGES_RESET;
  logic [OVF_W-1:0]   ovf_count = '0;
  logic [STAMP_W-1:0] last_stamp = '0;
  logic [EDGE_W-1:0]  edge_cnt = '0;

  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_run = 0;
  stall_mode_t stall_mode = STALL_NONE;

  logic [CAP_W-1:0] timer_low = '0;

  capture_period_speed_meter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_capture_value (in_capture_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_speed_q8     (out_speed_q8),
    .out_speed_level  (out_speed_level),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_speed(meter_word_t w);
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] period;
    logic [63:0]        divide;
    logic [63:0]        denom;
    logic [63:0]        speed;
    logic [63:0]        level;
    speed_result_t      res;
    if (!w.is_capture) begin
      ovf_count = ovf_count + 1'b1;
      return;
    end
    edge_cnt = edge_cnt + 1'b1;
    if (edge_cnt != edges_cfg) return;
    stamp = {ovf_count, w.capture};
    period = stamp - last_stamp;
    last_stamp = stamp;
    edge_cnt = '0;
    case (prescale_cfg)
      PRE_DIV1:    divide = 64'd1;
      PRE_DIV8:    divide = 64'd8;
      PRE_DIV64:   divide = 64'd64;
      PRE_DIV256:  divide = 64'd256;
      PRE_DIV1024: divide = 64'd1024;
      default:     divide = 64'd0;
    endcase
    if (divide == 0 || period == 0) begin
      res.speed = '1;
      res.level = '1;
      res.status = (divide == 0) ? STATUS_STOP : STATUS_ZERO;
    end else begin
      denom = 64'(period) * divide;
      speed = 64'(numerator_cfg) / denom;
      level = (64'(numerator_cfg) * LEVEL_PERCENT) / (denom << 8);
      level = (level * LEVEL_OUT_SPAN) / LEVEL_IN_SPAN;
      res.speed = (speed > SPEED_MAX) ? '1 : speed[SPEED_W-1:0];
      res.level = (level > LEVEL_MAX) ? '1 : level[LEVEL_W-1:0];
      res.status = STATUS_OK;
    end
    expected_speeds.push_back(res);
  endfunction

  // Sender: bursts of words with random gaps, fed from the pending queue.
  always @(posedge clk) begin
    meter_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_speed({in_action, in_capture_value});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= w.is_capture;
          in_capture_value <= w.capture;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, plus long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_run = $urandom_range(1, 150);
      end
      stall_run--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    speed_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_speeds.size() == 0) begin
        $error("Result word with none expected: speed_q8 %0d, speed_level %0d, status %0d",
               out_speed_q8, out_speed_level, out_status);
        failures++;
      end else begin
        want = expected_speeds.pop_front();
        if (out_speed_q8 !== want.speed) begin
          $error("speed_q8 mismatch: expected %0d, got %0d", want.speed, out_speed_q8);
          failures++;
        end
        if (out_speed_level !== want.level) begin
          $error("speed_level mismatch: expected %0d, got %0d", want.level, out_speed_level);
          failures++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
      end
    end
  end

  task automatic push_word(logic is_capture, logic [CAP_W-1:0] value);
    pending_words.push_back('{is_capture, value});
    words_queued++;
  endtask

  // Words from a free-running timer model: overflow ticks, then a capture word, with random noise words mixed in.
  task automatic push_timed_edges(int edge_total, int noise_pct);
    int          edges_done;
    int          step;
    logic [31:0] next_time;
    edges_done = 0;
    while (edges_done < edge_total) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        push_word(1'($urandom_range(0, 1)), 16'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       step = $urandom_range(0, 3);
          1:       step = $urandom_range(4, 300);
          2:       step = $urandom_range(301, 20000);
          default: step = $urandom_range(20001, 200000);
        endcase
        next_time = 32'(timer_low) + step;
        repeat (next_time[31:16]) push_word(1'b0, 16'($urandom));
        timer_low = next_time[15:0];
        push_word(1'b1, timer_low);
        edges_done++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_speeds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [NUM_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PRESCALE:  prescale_cfg = data[PRE_W-1:0];
      CFG_NUMERATOR: numerator_cfg = data;
      CFG_EDGES:     edges_cfg = data[EDGE_W-1:0];
      default:       ;
    endcase
  endtask

  initial begin
    logic [NUM_W-1:0] rnd;
    logic [NUM_W-1:0] numerator;
    pre_code_t        prescale_cycle[8];
    int               phase_end;
    int               p;
    prescale_cycle = '{PRE_STOPPED, PRE_DIV8, PRE_DIV1, PRE_DIV64,
                       PRE_UNUSED6, PRE_DIV256, PRE_DIV1024, PRE_UNUSED7};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The first measurement counts from a zero timestamp.
    push_word(1'b1, 16'h0000);
    push_word(1'b1, 16'h8000);
    push_word(1'b1, 16'h7FFF);
    push_word(1'b1, 16'hFFFF);
    // A period of one tick.
    push_word(1'b0, 16'hABCD);
    push_word(1'b1, 16'h1111);
    push_word(1'b1, 16'h2222);
    push_word(1'b1, 16'h3333);
    push_word(1'b1, 16'h0000);
    // Zero period, then a sample with a plain period.
    push_word(1'b1, 16'h1234);
    push_word(1'b1, 16'h5678);
    push_word(1'b1, 16'h9ABC);
    push_word(1'b1, 16'h0000);
    push_word(1'b0, 16'h5555);
    push_word(1'b1, 16'h4000);
    push_word(1'b1, 16'h8000);
    push_word(1'b1, 16'hC000);
    push_word(1'b1, 16'hFFFF);
    // The timestamp goes backwards, so the period wraps.
    push_word(1'b1, 16'h0001);
    push_word(1'b1, 16'h0002);
    push_word(1'b1, 16'h0003);
    push_word(1'b1, 16'h0005);
    wait_idle();

    // A stopped prescaler wins over a zero period.
    rnd = 40'({$urandom, $urandom});
    cfg_write(CFG_PRESCALE, {rnd[NUM_W-1:PRE_W], PRE_STOPPED});
    cfg_write(CFG_EDGES, {rnd[NUM_W-1:EDGE_W], 8'd1});
    cfg_write(CFG_UNUSED, rnd);
    push_word(1'b1, 16'h0005);
    push_word(1'b1, 16'h1000);
    wait_idle();

    cfg_write(CFG_PRESCALE, {37'd0, PRE_DIV1});
    cfg_write(CFG_NUMERATOR, NUMERATOR_MAX);
    push_word(1'b1, 16'h1001);
    wait_idle();
    cfg_write(CFG_NUMERATOR, '0);
    push_word(1'b1, 16'h2000);
    wait_idle();

    // Full sample at the largest edges setting, then the setting drops below the edge count.
    rnd = 40'({$urandom, $urandom});
    cfg_write(CFG_PRESCALE, {rnd[NUM_W-1:PRE_W], PRE_DIV64});
    cfg_write(CFG_NUMERATOR, rnd >> $urandom_range(0, 8));
    cfg_write(CFG_EDGES, {rnd[NUM_W-1:EDGE_W], 8'd255});
    push_timed_edges(255 + 250, 0);
    wait_idle();
    cfg_write(CFG_EDGES, {rnd[NUM_W-1:EDGE_W], 8'd0});
    push_timed_edges(6, 0);
    wait_idle();

    p = 0;
    while (words_queued < ITEM_TARGET) begin
      rnd = 40'({$urandom, $urandom});
      cfg_write(CFG_PRESCALE, {rnd[NUM_W-1:PRE_W], prescale_cycle[p % 8]});
      case (p % 4)
        0:       numerator = NUMERATOR_MAX;
        1:       numerator = rnd >> $urandom_range(0, 39);
        2:       numerator = NUMERATOR_RESET;
        default: numerator = rnd >> 20;
      endcase
      cfg_write(CFG_NUMERATOR, numerator);
      cfg_write(CFG_EDGES, {rnd[NUM_W-1:EDGE_W],
                            (p == 1) ? 8'd1 : 8'($urandom_range(1, 4))});
      if (p % 3 == 0) cfg_write(CFG_UNUSED, ~rnd);
      if (p == 1) hold_requests++;
      phase_end = words_queued + $urandom_range(50, 90);
      while (words_queued < phase_end) push_timed_edges(1, 10);
      wait_idle();
      p++;
    end

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
